// File: rtl/hash_set_duplicate_detector_top_assert.svh
// Assertion macros shared by the duplicate detector checker.
`ifndef HASH_SET_DUPLICATE_DETECTOR_TOP_ASSERT_SVH
`define HASH_SET_DUPLICATE_DETECTOR_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HSDD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define HSDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hsdd_pkg.sv
// Shared types and constants of the duplicate detector.
`timescale 1ns / 1ps

package hsdd_pkg;

   // Entries in the value pool, one cell each
   localparam int unsigned POOL_ENTRIES = 128;

   typedef struct packed {
      logic signed [31:0] value;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] echo_value;
      logic               is_repeat;
      logic               done_res;
      logic               none_repeated;
      logic               overflow;
   } rsp_type;

   // Item travelling along the cell row
   typedef struct packed {
      logic               vld;
      logic signed [31:0] value;
      logic               last;
      logic               found;
      logic               stored;
   } tok_type;

endpackage

// File: rtl/hsdd_cell.sv
// One pool cell: holds one stored value and checks each passing item.
`timescale 1ns / 1ps

module hsdd_cell import hsdd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  tok_type tok_in,
   output tok_type tok_out
);

   tok_type            tok_ff;
   logic               entry_valid_ff;
   logic               entry_valid_in;
   logic signed [31:0] entry_value_ff;
   logic signed [31:0] entry_value_in;
   logic               hit;
   logic               claim;

   // Compare the item here against the stored entry
   assign hit = tok_ff.vld && entry_valid_ff && (entry_value_ff == tok_ff.value);

   // First free cell seen by a new value takes it
   assign claim = tok_ff.vld && !entry_valid_ff && !tok_ff.found && !tok_ff.stored;

   // Pass the item on with its updated flags
   always_comb begin
      tok_out        = tok_ff;
      tok_out.found  = tok_ff.found | hit;
      tok_out.stored = tok_ff.stored | claim;
   end

   // Store on claim; drop the entry when the set's last item passes
   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_value_in = entry_value_ff;
      if (tok_ff.vld && tok_ff.last) begin
         entry_valid_in = 1'b0;
      end else if (claim) begin
         entry_valid_in = 1'b1;
         entry_value_in = tok_ff.value;
      end
   end

   // Hold everything while the row is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff         <= '0;
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         tok_ff         <= tok_in;
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_value_ff <= entry_value_in;
      end
   end

endmodule

// File: rtl/hash_set_duplicate_detector_top.sv
// Top level of the duplicate detector: request row of pool cells and result register.
//
//   Channel  Ports                          Moves
//   req      req_valid req_ready req_data   one value with its end-of-set flag
//   rsp      rsp_valid rsp_ready rsp_data   one result for each value, in order
//
// Items march through a row of POOL_ENTRIES cells, one cell per cycle while the row
// advances, and up to one new item enters each such cycle. The result is registered
// as the item leaves the last cell. Cells fill in arrival order; the last item of a
// set empties each cell as it passes. Reset empties every cell at once. A stalled
// result freezes the whole row and req_ready drops with it.
`timescale 1ns / 1ps

module hash_set_duplicate_detector_top import hsdd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   tok_type link [POOL_ENTRIES+1];
   tok_type tail;
   logic    advance;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    repeat_seen_ff;
   logic    repeat_seen_in;

   // Move the row whenever the result register can take a new item
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Wrap the incoming item for the row
   always_comb begin
      link[0]        = '0;
      link[0].vld    = req_valid;
      link[0].value  = req_data.value;
      link[0].last   = req_data.set_end;
   end

   genvar gi;
   generate
      for (gi = 0; gi < POOL_ENTRIES; gi++) begin : g_cell
         hsdd_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .tok_in  (link[gi]),
            .tok_out (link[gi+1])
         );
      end
   endgenerate

   assign tail = link[POOL_ENTRIES];

   // Build the result from the item leaving the row
   always_comb begin
      rsp_data_in.echo_value    = tail.value;
      rsp_data_in.is_repeat     = tail.found;
      rsp_data_in.done_res      = tail.last;
      rsp_data_in.none_repeated = tail.last && !(repeat_seen_ff || tail.found);
      rsp_data_in.overflow      = !tail.found && !tail.stored;
      repeat_seen_in            = tail.last ? 1'b0 : (repeat_seen_ff || tail.found);
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         repeat_seen_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.vld;
         if (tail.vld) begin
            repeat_seen_ff <= repeat_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.vld) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/hsdd_checker.sv
// Port-level checks of the duplicate detector, bound to the top level.
`timescale 1ns / 1ps
`include "hash_set_duplicate_detector_top_assert.svh"

module hsdd_checker import hsdd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A set summary appears only on the set's last item
   `HSDD_ASSERT_SAME(a_none_only_at_end, clock, reset, rsp_valid && !rsp_data.done_res, !rsp_data.none_repeated, "none_repeated without done_res")

   // A repeat is found, so it never overflows the pool
   `HSDD_ASSERT_SAME(a_repeat_no_overflow, clock, reset, rsp_valid && rsp_data.is_repeat, !rsp_data.overflow, "repeat and overflow together")

   // A repeat on the last item rules out a clean set
   `HSDD_ASSERT_SAME(a_repeat_end_not_clean, clock, reset, rsp_valid && rsp_data.is_repeat && rsp_data.done_res, !rsp_data.none_repeated, "clean set reported with a repeat")

   // Hold a stalled result
   `HSDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Hold a waiting request
   `HSDD_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data), "waiting request changed")

endmodule

bind hash_set_duplicate_detector_top hsdd_checker u_hsdd_checker (.*);

// File: verif/tb.sv
// Testbench for the duplicate detector: directed and random sets checked against a predictor.
`timescale 1ns / 1ps

module tb;
   import hsdd_pkg::*;

   localparam int BUCKET_COUNT   = 128;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = POOL_ENTRIES + 16;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Predicted table contents for the current set
   logic               bucket_live  [BUCKET_COUNT];
   int unsigned        bucket_first [BUCKET_COUNT];
   logic signed [31:0] entry_val    [POOL_ENTRIES];
   int unsigned        entry_next   [POOL_ENTRIES];
   int unsigned        fill_count;
   logic               repeat_in_set;

   rsp_type            pending_results [$];
   logic signed [31:0] set_history [$];
   int                 error_count    = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 quiet_cycles   = 0;

   hash_set_duplicate_detector_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Empty the predicted table at the end of a set
   function automatic void clear_set_state();
      for (int b = 0; b < BUCKET_COUNT; b++) begin
         bucket_live[b] = 1'b0;
      end
      fill_count    = 0;
      repeat_in_set = 1'b0;
   endfunction

   // Look the value up in its bucket chain, store it if new, and build the result
   function automatic rsp_type detect_repeat(input req_type item);
      rsp_type     res;
      int          rem;
      int unsigned bkt;
      int unsigned cur;
      int unsigned steps;
      logic        found;

      rem = int'(item.value) % BUCKET_COUNT;
      if (rem < 0) begin
         rem += BUCKET_COUNT;
      end
      bkt   = rem;
      found = 1'b0;
      res   = '0;

      // Walk the chain, bounded by the entries in use
      if (bucket_live[bkt]) begin
         cur   = bucket_first[bkt];
         steps = 0;
         while (steps < fill_count && cur < POOL_ENTRIES) begin
            if (entry_val[cur] == item.value) begin
               found = 1'b1;
               break;
            end
            if (entry_next[cur] == 0) begin
               break;
            end
            cur = entry_next[cur] - 1;
            steps++;
         end
      end

      if (found) begin
         repeat_in_set = 1'b1;
      end else if (fill_count < POOL_ENTRIES) begin
         // Link the new entry at the chain head
         entry_val[fill_count]  = item.value;
         entry_next[fill_count] = bucket_live[bkt] ? bucket_first[bkt] + 1 : 0;
         bucket_first[bkt]      = fill_count;
         bucket_live[bkt]       = 1'b1;
         fill_count++;
      end else begin
         res.overflow = 1'b1;
      end

      res.echo_value = item.value;
      res.is_repeat  = found;
      res.done_res   = item.set_end;
      if (item.set_end) begin
         res.none_repeated = !repeat_in_set;
         clear_set_state();
      end
      return res;
   endfunction

   // Send one item, with random idle cycles ahead of it, and record its result
   task automatic send_item(input logic signed [31:0] value, input logic last);
      req_type item;

      item.value   = value;
      item.set_end = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_results.push_back(detect_repeat(item));
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            check_field("echo_value", exp_res.echo_value, rsp_data.echo_value);
            check_field("is_repeat", 32'(exp_res.is_repeat), 32'(rsp_data.is_repeat));
            check_field("done_res", 32'(exp_res.done_res), 32'(rsp_data.done_res));
            check_field("none_repeated", 32'(exp_res.none_repeated),
                        32'(rsp_data.none_repeated));
            check_field("overflow", 32'(exp_res.overflow), 32'(rsp_data.overflow));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Extremes of the value range, each seen twice
   task automatic test_value_extremes();
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(0, 1'b0);
      send_item(-1, 1'b0);
      send_item(1, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh7fff_ffff, 1'b1);
   endtask

   // Several values in one bucket, negative ones among them
   task automatic test_bucket_collisions();
      send_item(1, 1'b0);
      send_item(129, 1'b0);
      send_item(-127, 1'b0);
      send_item(257, 1'b0);
      send_item(-255, 1'b0);
      send_item(129, 1'b0);
      send_item(-127, 1'b0);
      send_item(5, 1'b1);
   endtask

   // One-item sets, a set with no repeat and a set ending on a repeat
   task automatic test_short_sets();
      send_item(0, 1'b1);
      send_item(0, 1'b1);
      send_item(-1, 1'b1);
      send_item(10, 1'b0);
      send_item(11, 1'b1);
      send_item(7, 1'b0);
      send_item(7, 1'b1);
   endtask

   // Fill the pool, then send new values and repeats past the limit
   task automatic test_pool_overflow();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         send_item(i * 37 - 2000, 1'b0);
      end
      send_item(999_999, 1'b0);
      send_item(999_999, 1'b1);
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         send_item(-i * 129 + 77, 1'b0);
      end
      send_item(-5 * 129 + 77, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(77, 1'b1);
   endtask

   // Draw a value: reuse one of the set, hit a used bucket, an extreme or anything
   function automatic logic signed [31:0] pick_set_value(input int reuse_pct);
      int k;
      int idx;

      k = $urandom_range(0, 99);
      if (set_history.size() != 0 && k < reuse_pct) begin
         idx = $urandom_range(0, set_history.size() - 1);
         return set_history[idx];
      end
      if (set_history.size() != 0 && k < 60) begin
         idx = $urandom_range(0, set_history.size() - 1);
         return set_history[idx] + (int'($urandom_range(0, 8)) - 4) * BUCKET_COUNT;
      end
      if (k < 70) begin
         case ($urandom_range(0, 6))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3: return -1;
            4: return 127;
            5: return 128;
            default: return -128;
         endcase
      end
      return $urandom;
   endfunction

   // Random sets, mostly short, now and then long enough to fill the pool
   task automatic test_random_sets(input int budget);
      int sent;
      int len;
      int sel;
      int reuse_pct;
      logic signed [31:0] v;

      sent = 0;
      while (sent < budget) begin
         set_history.delete();
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            len = 1;
         end else if (sel < 93) begin
            len = $urandom_range(2, 16);
         end else begin
            len = $urandom_range(POOL_ENTRIES - 8, POOL_ENTRIES + 24);
         end
         reuse_pct = (len > 16) ? 8 : 35;
         for (int i = 0; i < len; i++) begin
            v = pick_set_value(reuse_pct);
            send_item(v, i == len - 1);
            set_history.push_back(v);
            sent++;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_set_state();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         entry_val[i]  = '0;
         entry_next[i] = 0;
      end
      for (int b = 0; b < BUCKET_COUNT; b++) begin
         bucket_first[b] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_value_extremes();
      test_bucket_collisions();
      test_short_sets();
      set_idling(18, 18);
      test_pool_overflow();

      set_idling(0, 0);
      test_random_sets(240);
      set_idling(58, 0);
      test_random_sets(240);
      set_idling(0, 58);
      test_random_sets(240);
      set_idling(18, 18);
      test_random_sets(240);

      // Drain the row, then let it settle
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/hsdd_pkg.sv
rtl/hsdd_cell.sv
rtl/hash_set_duplicate_detector_top.sv
rtl/hsdd_checker.sv
verif/tb.sv
